// ----- rtl/dlls_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dlls_pkg
// Types, constants and helpers for the debounced LED level stepper.
// ----------------------------------------------------------------------------
package dlls_pkg;

   // Default full-scale duty value, also the ceiling of the effective maximum.
   localparam int LEVEL_RANGE_DEFAULT = 32;

   localparam int LEVEL_W = 6;
   localparam int MODE_W  = 2;
   localparam int TIMER_W = 12;
   localparam int CSR_W   = 12;

   localparam logic [TIMER_W-1:0] TIMER_MAX = '1;

   localparam logic [MODE_W-1:0] MODE_OFF = 2'd0;
   localparam logic [MODE_W-1:0] MODE_ON  = 2'd1;
   localparam logic [MODE_W-1:0] MODE_MAX = 2'd2;

   localparam logic CSR_MAX_LEVEL   = 1'b0;
   localparam logic CSR_DEBOUNCE_MS = 1'b1;

   localparam logic [LEVEL_W-1:0] MAX_LEVEL_RESET   = 6'd5;
   localparam logic [TIMER_W-1:0] DEBOUNCE_MS_RESET = 12'd200;

   typedef struct packed {
      logic up_press;
      logic down_press;
   } req_type;

   typedef struct packed {
      logic [LEVEL_W-1:0] brightness_level;
      logic [LEVEL_W-1:0] duty_value;
      logic [MODE_W-1:0]  level_mode;
      logic               press_taken;
   } rsp_type;

   // Mode that follows a level for a given effective maximum.
   function automatic logic [MODE_W-1:0] mode_of(input logic [LEVEL_W-1:0] level,
                                                input logic [LEVEL_W-1:0] top);
      logic [MODE_W-1:0] mode;
      if (level == '0) begin
         mode = MODE_OFF;
      end else if (level >= top) begin
         mode = MODE_MAX;
      end else begin
         mode = MODE_ON;
      end
      return mode;
   endfunction

endpackage

// ----- rtl/debounced_led_level_stepper.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// debounced_led_level_stepper
// Two debounced buttons step a brightness level; each transaction reports
// the level, its mode and a duty word LEVEL_RANGE * level / top, the effective maximum.
// ----------------------------------------------------------------------------
// Each accepted request runs the restoring divider over a NUM_W-bit numerator,
// where NUM_W = clog2(LEVEL_RANGE + 1) + 6 (12 bits by default), one quotient
// bit per cycle, then ST_HOLD registers the result out. req_ready is low until
// the block is back in ST_IDLE; a result still waiting for rsp_ready holds the
// next one, and so the input, until it is taken.
// Reset (synchronous, active high) clears the level, mode and both debounce
// timers and loads max_level = 5 and debounce_ms = 200.
module debounced_led_level_stepper #(
   parameter int LEVEL_RANGE = dlls_pkg::LEVEL_RANGE_DEFAULT
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_ready,
   input  dlls_pkg::req_type            req_data,
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output dlls_pkg::rsp_type            rsp_data,
   input  logic                         csr_we,
   input  logic                         csr_index,
   input  logic [dlls_pkg::CSR_W-1:0]   csr_wdata
);
   import dlls_pkg::*;

   localparam int Q_W   = $clog2(LEVEL_RANGE + 1);
   localparam int NUM_W = Q_W + LEVEL_W;
   localparam int CNT_W = $clog2(NUM_W);
   localparam logic [8:0] RANGE_9 = 9'(LEVEL_RANGE);

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_DIV  = 2'd1;
   localparam logic [1:0] ST_HOLD = 2'd2;

   logic [1:0]         state_ff, state_in;
   logic [LEVEL_W-1:0] max_level_ff, max_level_in;
   logic [TIMER_W-1:0] debounce_ff, debounce_in;
   logic [TIMER_W-1:0] up_elapsed_ff, up_elapsed_in;
   logic [TIMER_W-1:0] down_elapsed_ff, down_elapsed_in;
   logic [LEVEL_W-1:0] level_ff, level_in;
   logic [MODE_W-1:0]  mode_ff, mode_in;
   logic               taken_ff, taken_in;
   logic [NUM_W-1:0]   num_ff, num_in;
   logic [LEVEL_W-1:0] rem_ff, rem_in;
   logic [LEVEL_W-1:0] div_ff, div_in;
   logic [CNT_W-1:0]   cnt_ff, cnt_in;
   logic               rsp_valid_ff, rsp_valid_in;
   rsp_type            rsp_ff, rsp_in;

   logic               req_fire;
   logic [LEVEL_W-1:0] top;
   logic [LEVEL_W-1:0] lvl_clamped, lvl_after_down, lvl_next;
   logic [TIMER_W-1:0] up_tick, down_tick;
   logic               up_ok, down_ok;
   logic [LEVEL_W:0]   rem_shift;
   logic               q_bit;
   logic               out_free;

   assign req_ready = (state_ff == ST_IDLE);
   assign req_fire  = req_valid && req_ready;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;
   assign out_free  = !rsp_valid_ff || rsp_ready;

   // Effective maximum: zero acts as one, and the ceiling is LEVEL_RANGE.
   always_comb begin
      priority if (max_level_ff == '0) begin
         top = LEVEL_W'(1);
      end else if ({3'b000, max_level_ff} > RANGE_9) begin
         top = LEVEL_W'(LEVEL_RANGE);
      end else begin
         top = max_level_ff;
      end
   end

   // Per-tick step: clamp, advance both timers, then apply down before up.
   always_comb begin
      lvl_clamped = (level_ff > top) ? top : level_ff;
      up_tick     = (up_elapsed_ff   == TIMER_MAX) ? TIMER_MAX : up_elapsed_ff + 1'b1;
      down_tick   = (down_elapsed_ff == TIMER_MAX) ? TIMER_MAX : down_elapsed_ff + 1'b1;
      up_ok       = req_data.up_press   && (up_tick   >= debounce_ff);
      down_ok     = req_data.down_press && (down_tick >= debounce_ff);
      lvl_after_down = (down_ok && lvl_clamped != '0) ? lvl_clamped - 1'b1 : lvl_clamped;
      lvl_next       = (up_ok && lvl_after_down < top) ? lvl_after_down + 1'b1
                                                       : lvl_after_down;
   end

   // One restoring division step; the quotient bit enters the numerator LSB.
   always_comb begin
      rem_shift = {rem_ff, num_ff[NUM_W-1]};
      q_bit     = (rem_shift >= {1'b0, div_ff});
   end

   always_comb begin
      state_in        = state_ff;
      max_level_in    = max_level_ff;
      debounce_in     = debounce_ff;
      up_elapsed_in   = up_elapsed_ff;
      down_elapsed_in = down_elapsed_ff;
      level_in        = level_ff;
      mode_in         = mode_ff;
      taken_in        = taken_ff;
      num_in          = num_ff;
      rem_in          = rem_ff;
      div_in          = div_ff;
      cnt_in          = cnt_ff;
      rsp_valid_in    = rsp_valid_ff && !rsp_ready;
      rsp_in          = rsp_ff;

      if (csr_we) begin
         unique case (csr_index)
            CSR_MAX_LEVEL:   max_level_in = csr_wdata[LEVEL_W-1:0];
            CSR_DEBOUNCE_MS: debounce_in  = csr_wdata[TIMER_W-1:0];
            default:         ;
         endcase
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               up_elapsed_in   = up_ok   ? '0 : up_tick;
               down_elapsed_in = down_ok ? '0 : down_tick;
               level_in        = lvl_next;
               mode_in         = mode_of(lvl_next, top);
               taken_in        = up_ok || down_ok;
               num_in          = NUM_W'(LEVEL_RANGE) * NUM_W'(lvl_next);
               rem_in          = '0;
               div_in          = top;
               cnt_in          = CNT_W'(NUM_W - 1);
               state_in        = ST_DIV;
            end
         end
         ST_DIV: begin
            rem_in = q_bit ? LEVEL_W'(rem_shift - {1'b0, div_ff}) : LEVEL_W'(rem_shift);
            num_in = {num_ff[NUM_W-2:0], q_bit};
            cnt_in = cnt_ff - 1'b1;
            if (cnt_ff == '0) begin
               state_in = ST_HOLD;
            end
         end
         ST_HOLD: begin
            if (out_free) begin
               rsp_valid_in             = 1'b1;
               rsp_in.brightness_level  = level_ff;
               rsp_in.duty_value        = num_ff[LEVEL_W-1:0];
               rsp_in.level_mode        = mode_ff;
               rsp_in.press_taken       = taken_ff;
               state_in                 = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= ST_IDLE;
         max_level_ff    <= MAX_LEVEL_RESET;
         debounce_ff     <= DEBOUNCE_MS_RESET;
         up_elapsed_ff   <= '0;
         down_elapsed_ff <= '0;
         level_ff        <= '0;
         mode_ff         <= MODE_OFF;
         taken_ff        <= 1'b0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         state_ff        <= state_in;
         max_level_ff    <= max_level_in;
         debounce_ff     <= debounce_in;
         up_elapsed_ff   <= up_elapsed_in;
         down_elapsed_ff <= down_elapsed_in;
         level_ff        <= level_in;
         mode_ff         <= mode_in;
         taken_ff        <= taken_in;
         rsp_valid_ff    <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      num_ff <= num_in;
      rem_ff <= rem_in;
      div_ff <= div_in;
      cnt_ff <= cnt_in;
      rsp_ff <= rsp_in;
   end

endmodule
